/* rtl/ala_pkg.sv */
// ala_pkg: shared constants and types of the address lease allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ala_pkg;
  localparam int NUM_SLOTS_DEF     = 64;
  localparam int LEASE_ENTRIES_DEF = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_PREFIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_START     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COUNT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEASE_DURATION = 2'd3;

  localparam logic [23:0] SUBNET_RESET   = 24'hC0A801;
  localparam logic [7:0]  START_RESET    = 8'd100;
  localparam logic [6:0]  COUNT_RESET    = 7'd50;
  localparam logic [31:0] DURATION_RESET = 32'd3600;

  localparam logic [1:0] OP_DISCOVER = 2'd0;
  localparam logic [1:0] OP_REQUEST  = 2'd1;
  localparam logic [1:0] OP_SWEEP    = 2'd2;

  localparam logic [2:0] ST_OFFER      = 3'd0;
  localparam logic [2:0] ST_NO_FREE    = 3'd1;
  localparam logic [2:0] ST_ACK        = 3'd2;
  localparam logic [2:0] ST_NAK        = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_SWEEP_DONE = 3'd5;

  typedef struct packed {
    logic [23:0] subnet_prefix;
    logic [7:0]  host_base;
    logic [6:0]  pool_count;
    logic [31:0] lease_duration;
  } cfg_t;
endpackage
`default_nettype wire

/* rtl/ala_cfg.sv */
// ala_cfg: configuration register file
// depends on ala_pkg
`timescale 1ns / 1ps
`default_nettype none
module ala_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ala_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ala_pkg::CFG_DATA_W-1:0] cfg_data,
  output ala_pkg::cfg_t                      cfg
);
  import ala_pkg::*;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.subnet_prefix  <= SUBNET_RESET;
      cfg.host_base      <= START_RESET;
      cfg.pool_count     <= COUNT_RESET;
      cfg.lease_duration <= DURATION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SUBNET_PREFIX:  cfg.subnet_prefix  <= cfg_data[23:0];
        REG_POOL_START:     cfg.host_base      <= cfg_data[7:0];
        REG_POOL_COUNT:     cfg.pool_count     <= cfg_data[6:0];
        REG_LEASE_DURATION: cfg.lease_duration <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/address_lease_allocator_top.sv */
// address_lease_allocator_top: lease table sequencer with entry memory
// depends on ala_pkg, ala_cfg
//
// usage: pulse start while busy is low with operation, client_mac,
// requested_address and current_time. exactly one result follows, shown
// for one cycle with done high; the receiver cannot stall it.
// entry fields (mac, slot, expiry) live in a memory with registered read;
// valid flags and the in-use bitmap are flip-flops cleared at reset.
// every operation walks all LEASE_ENTRIES entries through the memory
// read port, one per cycle, then finishes the walk in S_LAST, decides in
// S_DECIDE and writes back in S_WRITE, with done high in S_WRITE; the next
// transfer is taken once the state is back in S_IDLE. the free slot search
// walks the bitmap one slot a cycle alongside the entry walk and S_LAST
// waits for it to end, so a pool above LEASE_ENTRIES can lengthen an item.
// configuration writes (cfg_we, cfg_index, cfg_data) apply at once; the
// user must make them only while busy is low: the block does not enforce
// it. reset returns the registers to their defaults and empties the table;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module address_lease_allocator_top #(
  parameter int NUM_SLOTS     = ala_pkg::NUM_SLOTS_DEF,
  parameter int LEASE_ENTRIES = ala_pkg::LEASE_ENTRIES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output      logic                           busy,
  input  wire logic [1:0]                     operation,
  input  wire logic [47:0]                    client_mac,
  input  wire logic [31:0]                    requested_address,
  input  wire logic [31:0]                    current_time,
  output      logic                           done,
  output      logic [2:0]                     status,
  output      logic [31:0]                    address,
  output      logic [6:0]                     freed_count,
  input  wire logic                           cfg_we,
  input  wire logic [ala_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ala_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ala_pkg::*;

  localparam int EW = (LEASE_ENTRIES > 1) ? $clog2(LEASE_ENTRIES) : 1;
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(LEASE_ENTRIES + 1);
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam int MW = 48 + SW + 32;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_DECIDE, S_WRITE} state_t;

  cfg_t cfg;
  ala_cfg u_cfg (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg);

  logic [MW-1:0] mem [LEASE_ENTRIES];
  logic [MW-1:0] rd_data;
  logic [EW-1:0] rd_addr;
  logic          wr_en;
  logic [EW-1:0] wr_addr;
  logic [MW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [LEASE_ENTRIES-1:0] valid;
  logic [NUM_SLOTS-1:0]     in_use;

  state_t        state;
  logic [1:0]    op;
  logic [47:0]   mac;
  logic [31:0]   req;
  logic [31:0]   now;
  logic [CW-1:0] cnt;
  logic [EW-1:0] rd_e;
  logic          rd_v;
  logic          hit;
  logic [EW-1:0] hit_e;
  logic [SW-1:0] hit_slot;
  logic          free_e_found;
  logic [EW-1:0] free_e;
  logic [PW-1:0] scnt;
  logic          slot_found;
  logic [SW-1:0] free_slot;
  logic [6:0]    freed;

  logic [47:0]   rd_mac;
  logic [SW-1:0] rd_slot;
  logic [31:0]   rd_exp;
  assign rd_mac  = rd_data[MW-1 -: 48];
  assign rd_slot = rd_data[32 +: SW];
  assign rd_exp  = rd_data[31:0];

  logic [PW-1:0] limit;
  always_comb begin
    if (32'(cfg.pool_count) > NUM_SLOTS) limit = PW'(NUM_SLOTS);
    else limit = PW'(cfg.pool_count);
  end

  logic [32:0] sum;
  logic [31:0] expiry;
  assign sum = {1'b0, now} + {1'b0, cfg.lease_duration};
  assign expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  function automatic logic [31:0] slot_addr(input cfg_t c, input logic [SW-1:0] s);
    logic [7:0] h;
    h = c.host_base + 8'(s);
    return {c.subnet_prefix, h};
  endfunction

  logic [31:0] hit_addr;
  assign hit_addr = slot_addr(cfg, hit_slot);

  logic req_ok;
  logic do_write;
  assign req_ok = hit && (hit_addr == req) && !in_use[hit_slot];
  always_comb begin
    case (op)
      OP_DISCOVER: do_write = hit || (slot_found && free_e_found);
      OP_REQUEST:  do_write = req_ok;
      default:     do_write = 1'b0;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign rd_addr = (state == S_IDLE) ? '0 : EW'(cnt);

  logic last_rd;
  assign last_rd  = (cnt == CW'(LEASE_ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      in_use <= '0;
      wr_en  <= 1'b0;
      done   <= 1'b0;
    end else begin
      wr_en <= (state == S_DECIDE) && do_write;
      done  <= (state == S_DECIDE);
      case (state)
        S_IDLE: begin
          if (start) begin
            op <= operation; mac <= client_mac;
            req <= requested_address; now <= current_time;
            cnt <= CW'(1); rd_e <= '0; rd_v <= 1'b1;
            hit <= 1'b0; free_e_found <= 1'b0;
            scnt <= '0; slot_found <= 1'b0; freed <= '0;
            state <= (LEASE_ENTRIES == 1) ? S_LAST : S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          // entry rd_e data is on rd_data now
          if (rd_v && valid[rd_e]) begin
            if (op == OP_SWEEP) begin
              if (rd_exp < now) begin
                valid[rd_e] <= 1'b0;
                if (32'(rd_slot) < NUM_SLOTS) in_use[rd_slot] <= 1'b0;
                if (freed != 7'd127) freed <= freed + 7'd1;
              end
            end else if (!hit && rd_mac == mac) begin
              hit <= 1'b1; hit_e <= rd_e; hit_slot <= rd_slot;
            end
          end else if (rd_v && !free_e_found) begin
            free_e_found <= 1'b1; free_e <= rd_e;
          end
          if (!slot_found && scnt < limit) begin
            if (!in_use[SW'(scnt)]) begin
              slot_found <= 1'b1; free_slot <= SW'(scnt);
            end
            scnt <= scnt + PW'(1);
          end
          rd_e <= EW'(cnt);
          if (state == S_LAST) begin
            rd_v <= 1'b0;
            if (slot_found || scnt >= limit || scnt == PW'(NUM_SLOTS))
              state <= S_DECIDE;
          end else begin
            rd_v <= !last_rd;
            cnt <= cnt + CW'(1);
            if (last_rd) state <= S_LAST;
          end
        end
        S_DECIDE: begin
          address <= '0; freed_count <= '0; status <= ST_NAK;
          case (op)
            OP_DISCOVER: begin
              if (hit) begin
                wr_addr <= hit_e;
                wr_data <= {mac, hit_slot, expiry};
                status <= ST_OFFER; address <= hit_addr;
              end else if (!slot_found) begin
                status <= ST_NO_FREE;
              end else if (!free_e_found) begin
                status <= ST_TABLE_FULL;
              end else begin
                wr_addr <= free_e;
                wr_data <= {mac, free_slot, expiry};
                valid[free_e] <= 1'b1;
                status <= ST_OFFER; address <= slot_addr(cfg, free_slot);
              end
            end
            OP_REQUEST: begin
              if (hit) begin
                if (req_ok) begin
                  wr_addr <= hit_e;
                  wr_data <= {mac, hit_slot, expiry};
                  in_use[hit_slot] <= 1'b1;
                  status <= ST_ACK; address <= req;
                end else begin
                  valid[hit_e] <= 1'b0;
                end
              end
            end
            OP_SWEEP: begin
              status <= ST_SWEEP_DONE; freed_count <= freed;
            end
            default: ;
          endcase
          // hold busy through S_WRITE so the write lands before the next item
          state <= S_WRITE;
        end
        S_WRITE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/ala_checker.sv */
// ala_checker: port-level assertions for the lease allocator
// depends on ala_pkg, address_lease_allocator_top
`timescale 1ns / 1ps
`default_nettype none
module ala_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [2:0]  status,
  input wire logic [31:0] address,
  input wire logic [6:0]  freed_count
);
  import ala_pkg::*;
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("transfer not taken");
  a_freed: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_SWEEP_DONE |-> freed_count == 7'd0)
    else $error("freed count outside a sweep");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result repeated");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_SWEEP_DONE) else $error("bad status");
  a_addr: assert property (@(posedge clk) disable iff (rst)
    done && !(status == ST_OFFER || status == ST_ACK) |-> address == 32'd0)
    else $error("address on a refusal");
endmodule

bind address_lease_allocator_top ala_checker u_ala_checker (
  .clk, .rst, .start, .busy, .done, .status, .address, .freed_count
);
`default_nettype wire
